// File: hdl/cht_pkg.sv
// ----------------------------------------------------------------------------
// Coalesced hash table package
// Payload types, status codes, controller states and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int KeyW     = 31;
  localparam int SlotW    = 4;
  localparam int StatusW  = 3;
  localparam int DigitW   = 4;
  localparam int DigitCnt = 8;
  localparam int DigCntW  = 3;

  localparam logic [StatusW-1:0] StHome    = 3'd0;
  localparam logic [StatusW-1:0] StFree    = 3'd1;
  localparam logic [StatusW-1:0] StFull    = 3'd2;
  localparam logic [StatusW-1:0] StDeleted = 3'd3;
  localparam logic [StatusW-1:0] StMissing = 3'd4;

  localparam logic OpInsert = 1'b0;
  localparam logic OpDelete = 1'b1;

  typedef struct packed {
    logic            operation;
    logic [KeyW-1:0] key;
  } in_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [SlotW-1:0]   slot;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_HOME,
    S_WALK,
    S_WALKD,
    S_CSTEP,
    S_FCHK,
    S_FUSED,
    S_SHRD,
    S_SHLN,
    S_SHKY,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic store_home;
    logic store_free;
    logic set_full;
    logic set_missing;
    logic rd_cur;
    logic walk_next;
    logic link_tail;
    logic cursor_dec;
    logic find_next;
    logic mark_found;
    logic sh_follow;
    logic sh_write;
    logic del_finish;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic op_del;
    logic mod_done;
    logic cur_used;
    logic cur_link;
    logic walk_done;
    logic key_hit;
    logic cursor_neg;
    logic cursor_stop;
    logic tail_is_dst;
    logic out_full;
  } sts_t;

endpackage

// File: hdl/cht_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cht_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/cht_datapath.sv
// ----------------------------------------------------------------------------
// Coalesced hash table datapath
// Key reduction, slot and link storage, occupancy marks, free cursor and the
// result register, all driven by commands from the controller.
// ----------------------------------------------------------------------------
module cht_datapath #(
  parameter int TableSize = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cht_pkg::in_t  in_data_i,
  input  cht_pkg::cmd_t cmd_i,
  output cht_pkg::sts_t sts_o,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output cht_pkg::out_t out_data_o
);

  localparam int IW = $clog2(TableSize);
  localparam int RW = IW + cht_pkg::DigitW;
  localparam int PadW = cht_pkg::DigitW * cht_pkg::DigitCnt;
  localparam int Radix = 2 ** cht_pkg::DigitW;
  localparam logic [IW:0] NVal = (IW+1)'(TableSize);
  localparam logic signed [IW:0] CursorReset = (IW+1)'(TableSize - 1);

  logic                        op_q;
  logic [cht_pkg::KeyW-1:0]    key_q;
  logic [cht_pkg::DigCntW-1:0] dig_q;
  logic [IW-1:0]               rem_q;
  logic [IW-1:0]               cur_q;
  logic [IW-1:0]               dst_q;
  logic [IW-1:0]               pred_q;
  logic [IW-1:0]               prev_q;
  logic [IW-1:0]               found_q;
  logic                        pred_v_q;
  logic                        prev_v_q;
  logic [IW:0]                 n_q;
  logic signed [IW:0]          cursor_q;
  logic [TableSize-1:0]        used_q;
  logic [TableSize-1:0]        lp_q;
  cht_pkg::out_t               res_q;
  cht_pkg::out_t               out_q;
  logic                        out_valid_q;

  logic [PadW-1:0]             key_pad;
  logic [cht_pkg::DigitW-1:0]  digit;
  logic [RW-1:0]               rem_sh;
  logic [IW-1:0]               rem_d;
  logic [IW-1:0]               cursor_idx;
  logic [IW:0]                 cur_ext;
  logic [TableSize-1:0]        lp_clr;

  logic                        key_we;
  logic [IW-1:0]               key_waddr;
  logic [cht_pkg::KeyW-1:0]    key_wdata;
  logic                        key_re;
  logic [IW-1:0]               key_raddr;
  logic [cht_pkg::KeyW-1:0]    key_rdata;
  logic [IW-1:0]               link_rdata;

  assign key_pad    = PadW'(key_q);
  assign digit      = key_pad[dig_q * cht_pkg::DigitW +: cht_pkg::DigitW];
  assign rem_sh     = {rem_q, digit};
  assign cursor_idx = cursor_q[IW-1:0];
  assign cur_ext    = {1'b0, cur_q};

  always_comb begin
    rem_d = IW'(rem_sh);
    for (int k = 1; k < Radix; k++) begin
      if (rem_sh >= RW'(k * TableSize)) begin
        rem_d = IW'(rem_sh - RW'(k * TableSize));
      end
    end
  end

  always_comb begin
    lp_clr        = '0;
    lp_clr[cur_q] = 1'b1;
    if (prev_v_q) begin
      lp_clr[prev_q] = 1'b1;
    end else if (pred_v_q) begin
      lp_clr[pred_q] = 1'b1;
    end
  end

  assign key_we    = cmd_i.store_home | cmd_i.store_free | cmd_i.sh_write;
  assign key_waddr = cmd_i.sh_write ? prev_q : (cmd_i.store_free ? cursor_idx : cur_q);
  assign key_wdata = cmd_i.sh_write ? key_rdata : key_q;
  assign key_re    = cmd_i.rd_cur | cmd_i.sh_follow;
  assign key_raddr = cmd_i.sh_follow ? link_rdata : cur_q;

  cht_ram #(
    .Width(cht_pkg::KeyW),
    .Depth(TableSize)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(key_waddr),
    .wdata_i(key_wdata),
    .re_i   (key_re),
    .raddr_i(key_raddr),
    .rdata_o(key_rdata)
  );

  cht_ram #(
    .Width(IW),
    .Depth(TableSize)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.link_tail),
    .waddr_i(cur_q),
    .wdata_i(dst_q),
    .re_i   (cmd_i.rd_cur),
    .raddr_i(cur_q),
    .rdata_o(link_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_data_i.operation;
      key_q <= in_data_i.key;
      dig_q <= cht_pkg::DigCntW'(cht_pkg::DigitCnt - 1);
      rem_q <= '0;
    end
    if (cmd_i.mod_step) begin
      rem_q <= rem_d;
      cur_q <= rem_d;
      dig_q <= dig_q - 1'b1;
    end
    if (cmd_i.store_home) begin
      res_q <= '{status: cht_pkg::StHome, slot: cht_pkg::SlotW'(cur_q)};
    end
    if (cmd_i.store_free) begin
      dst_q <= cursor_idx;
      res_q <= '{status: cht_pkg::StFree, slot: cht_pkg::SlotW'(cursor_idx)};
    end
    if (cmd_i.set_full) begin
      res_q <= '{status: cht_pkg::StFull, slot: '0};
    end
    if (cmd_i.set_missing) begin
      res_q <= '{status: cht_pkg::StMissing, slot: '0};
    end
    if (cmd_i.walk_next) begin
      cur_q <= link_rdata;
    end
    if (cmd_i.find_next) begin
      pred_q <= cur_q;
      cur_q  <= link_rdata;
    end
    if (cmd_i.mark_found) begin
      found_q <= cur_q;
    end
    if (cmd_i.sh_follow) begin
      prev_q <= cur_q;
      cur_q  <= link_rdata;
    end
    if (cmd_i.del_finish) begin
      res_q <= '{status: cht_pkg::StDeleted, slot: cht_pkg::SlotW'(found_q)};
    end
    if (cmd_i.emit) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_v_q    <= 1'b0;
      prev_v_q    <= 1'b0;
      n_q         <= '0;
      cursor_q    <= CursorReset;
      used_q      <= '0;
      lp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        pred_v_q <= 1'b0;
        prev_v_q <= 1'b0;
        n_q      <= '0;
      end
      if (cmd_i.store_home) begin
        used_q[cur_q] <= 1'b1;
        lp_q[cur_q]   <= 1'b0;
      end
      if (cmd_i.store_free) begin
        used_q[cursor_idx] <= 1'b1;
        lp_q[cursor_idx]   <= 1'b0;
      end
      if (cmd_i.link_tail) begin
        lp_q[cur_q] <= 1'b1;
      end
      if (cmd_i.walk_next || cmd_i.find_next || cmd_i.sh_write) begin
        n_q <= n_q + 1'b1;
      end
      if (cmd_i.find_next) begin
        pred_v_q <= 1'b1;
      end
      if (cmd_i.mark_found) begin
        n_q <= '0;
      end
      if (cmd_i.sh_follow) begin
        prev_v_q <= 1'b1;
      end
      if (cmd_i.cursor_dec) begin
        cursor_q <= cursor_q - 1'b1;
      end
      if (cmd_i.del_finish) begin
        used_q[cur_q] <= 1'b0;
        lp_q          <= lp_q & ~lp_clr;
        if (cursor_q < $signed(cur_ext)) begin
          cursor_q <= $signed(cur_ext);
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.op_del      = (op_q == cht_pkg::OpDelete);
  assign sts_o.mod_done    = (dig_q == '0);
  assign sts_o.cur_used    = used_q[cur_q];
  assign sts_o.cur_link    = lp_q[cur_q];
  assign sts_o.walk_done   = (n_q == NVal);
  assign sts_o.key_hit     = (key_rdata == key_q);
  assign sts_o.cursor_neg  = cursor_q[IW];
  assign sts_o.cursor_stop = cursor_q[IW] | ~used_q[cursor_idx];
  assign sts_o.tail_is_dst = (cur_q == dst_q);
  assign sts_o.out_full    = out_valid_q & out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hdl/cht_ctrl.sv
// ----------------------------------------------------------------------------
// Coalesced hash table controller
// State machine that sequences key reduction, chain walks, cursor steps,
// key shifts on delete and the hand-over of each result.
// ----------------------------------------------------------------------------
module cht_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cht_pkg::sts_t sts_i,
  output cht_pkg::cmd_t cmd_o
);

  cht_pkg::state_e state_q;
  cht_pkg::state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cht_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      cht_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = cht_pkg::S_MOD;
        end
      end
      cht_pkg::S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_done) begin
          state_d = cht_pkg::S_HOME;
        end
      end
      cht_pkg::S_HOME: begin
        if (sts_i.op_del) begin
          if (!sts_i.cur_used) begin
            cmd_o.set_missing = 1'b1;
            state_d           = cht_pkg::S_DONE;
          end else begin
            cmd_o.rd_cur = 1'b1;
            state_d      = cht_pkg::S_FCHK;
          end
        end else if (!sts_i.cur_used) begin
          cmd_o.store_home = 1'b1;
          state_d          = cht_pkg::S_CSTEP;
        end else if (!sts_i.cursor_neg) begin
          cmd_o.store_free = 1'b1;
          state_d          = cht_pkg::S_WALK;
        end else begin
          cmd_o.set_full = 1'b1;
          state_d        = cht_pkg::S_CSTEP;
        end
      end
      cht_pkg::S_WALK: begin
        if (!sts_i.walk_done && sts_i.cur_link) begin
          cmd_o.rd_cur = 1'b1;
          state_d      = cht_pkg::S_WALKD;
        end else begin
          cmd_o.link_tail = ~sts_i.tail_is_dst;
          state_d         = cht_pkg::S_CSTEP;
        end
      end
      cht_pkg::S_WALKD: begin
        cmd_o.walk_next = 1'b1;
        state_d         = cht_pkg::S_WALK;
      end
      cht_pkg::S_CSTEP: begin
        if (sts_i.cursor_stop) begin
          state_d = cht_pkg::S_DONE;
        end else begin
          cmd_o.cursor_dec = 1'b1;
        end
      end
      cht_pkg::S_FCHK: begin
        if (sts_i.key_hit) begin
          cmd_o.mark_found = 1'b1;
          state_d          = cht_pkg::S_SHRD;
        end else if (!sts_i.cur_link || sts_i.walk_done) begin
          cmd_o.set_missing = 1'b1;
          state_d           = cht_pkg::S_DONE;
        end else begin
          cmd_o.find_next = 1'b1;
          state_d         = cht_pkg::S_FUSED;
        end
      end
      cht_pkg::S_FUSED: begin
        if (!sts_i.cur_used) begin
          cmd_o.set_missing = 1'b1;
          state_d           = cht_pkg::S_DONE;
        end else begin
          cmd_o.rd_cur = 1'b1;
          state_d      = cht_pkg::S_FCHK;
        end
      end
      cht_pkg::S_SHRD: begin
        if (!sts_i.walk_done && sts_i.cur_link) begin
          cmd_o.rd_cur = 1'b1;
          state_d      = cht_pkg::S_SHLN;
        end else begin
          cmd_o.del_finish = 1'b1;
          state_d          = cht_pkg::S_DONE;
        end
      end
      cht_pkg::S_SHLN: begin
        cmd_o.sh_follow = 1'b1;
        state_d         = cht_pkg::S_SHKY;
      end
      cht_pkg::S_SHKY: begin
        cmd_o.sh_write = 1'b1;
        state_d        = cht_pkg::S_SHRD;
      end
      cht_pkg::S_DONE: begin
        if (!sts_i.out_full) begin
          cmd_o.emit = 1'b1;
          state_d    = cht_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cht_pkg::S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != cht_pkg::S_IDLE);

endmodule

// File: hdl/coalesced_hash_table.sv
// ----------------------------------------------------------------------------
// Coalesced hash table
// Keyed slot table with coalesced chaining, serving insert and delete
// requests one at a time and returning one result for each.
// ----------------------------------------------------------------------------
// The request channel carries an operation and a key; a transfer takes place
// when in_valid_i is high and in_stall_o is low. The result channel carries a
// status and a slot number, with out_valid_o held until a cycle in which
// out_stall_i is low.
// One request is processed at a time. The home slot is found by reducing the
// key four bits per cycle over eight digits. An insert then walks the chain
// node by node and steps the free cursor past each occupied slot; a delete
// searches the chain node by node and shifts each later key back by one node.
// The time a request takes is set by the key reduction and the chain walks
// through the registered-read slot memories.
// A stalled result waits in the output register; the next request may be
// taken meanwhile, and its result is held back until the register is free.
// Reset empties every slot and sets the free cursor to the top slot at once;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module coalesced_hash_table #(
  parameter int TableSize = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cht_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cht_pkg::out_t out_data_o
);

  cht_pkg::cmd_t cmd;
  cht_pkg::sts_t sts;

  cht_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  cht_datapath #(
    .TableSize(TableSize)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request channel not stalled after a transfer");

  a_result_follows_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result raised without a request in progress");

  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == cht_pkg::StHome ||
                     out_data_o.status == cht_pkg::StFree ||
                     out_data_o.status == cht_pkg::StFull ||
                     out_data_o.status == cht_pkg::StDeleted ||
                     out_data_o.status == cht_pkg::StMissing))
    else $error("result carries an unknown status code");

  a_empty_slot_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == cht_pkg::StFull ||
                     out_data_o.status == cht_pkg::StMissing))
      |-> (out_data_o.slot == '0))
    else $error("dropped or missing result carries a slot number");
`endif

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Coalesced hash table testbench
// Drives insert and delete requests through the valid/stall request channel
// and checks every result against a cycle-free model of the slot table, its
// chains and its free cursor. A directed opening covers empty and chained
// homes, duplicates, a full table and deletes at the head, middle and tail of
// a chain; random traffic from a small key pool then keeps the table churning
// near full while both channels idle in bursts, with one long result hold-off
// and one pause until every result has returned.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TableSize   = 16;
  localparam int RandomItems = 1226;
  localparam int CalmItems   = 150;
  localparam int LongHoldAt  = 420;
  localparam int PauseAt     = 860;
  localparam int LongHold    = 320;
  localparam int PoolSize    = 24;
  localparam int DrainCycles = 200;
  localparam int IdleLimit   = 4000;
  localparam int ReportLimit = 10;

  class chain_table_model;
    logic [cht_pkg::KeyW-1:0]  slot_key [TableSize];
    bit                        slot_used [TableSize];
    logic [cht_pkg::SlotW-1:0] slot_link [TableSize];
    bit                        link_valid [TableSize];
    int                        cursor;
    cht_pkg::out_t             pending [$];
    int                        faults;

    function new();
      foreach (slot_used[i]) begin
        slot_key[i]   = '0;
        slot_used[i]  = 1'b0;
        slot_link[i]  = '0;
        link_valid[i] = 1'b0;
      end
      cursor = TableSize - 1;
      faults = 0;
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    function cht_pkg::out_t insert_key(logic [cht_pkg::KeyW-1:0] key);
      int            home;
      int            dst;
      int            tail;
      cht_pkg::out_t res;
      home = int'(key % TableSize);
      if (!slot_used[home]) begin
        slot_key[home]   = key;
        slot_used[home]  = 1'b1;
        link_valid[home] = 1'b0;
        res = '{status: cht_pkg::StHome, slot: home[cht_pkg::SlotW-1:0]};
      end else if (cursor >= 0) begin
        dst = cursor;
        slot_key[dst]   = key;
        slot_used[dst]  = 1'b1;
        link_valid[dst] = 1'b0;
        tail = home;
        for (int n = 0; n < TableSize && link_valid[tail]; n++) tail = slot_link[tail];
        if (tail != dst) begin
          slot_link[tail]  = dst[cht_pkg::SlotW-1:0];
          link_valid[tail] = 1'b1;
        end
        res = '{status: cht_pkg::StFree, slot: dst[cht_pkg::SlotW-1:0]};
      end else begin
        res = '{status: cht_pkg::StFull, slot: '0};
      end
      while (cursor >= 0 && slot_used[cursor]) cursor--;
      return res;
    endfunction

    function cht_pkg::out_t delete_key(logic [cht_pkg::KeyW-1:0] key);
      int            k;
      int            pred;
      int            prev;
      int            found;
      int            n;
      cht_pkg::out_t res;
      res  = '{status: cht_pkg::StMissing, slot: '0};
      pred = -1;
      prev = -1;
      k    = int'(key % TableSize);
      if (!slot_used[k]) return res;
      n = 0;
      while (slot_key[k] != key) begin
        if (!link_valid[k] || n >= TableSize) return res;
        pred = k;
        k    = slot_link[k];
        if (!slot_used[k]) return res;
        n++;
      end
      found = k;
      for (n = 0; n < TableSize && link_valid[k]; n++) begin
        prev = k;
        k    = slot_link[k];
        slot_key[prev] = slot_key[k];
      end
      slot_used[k]  = 1'b0;
      link_valid[k] = 1'b0;
      if (prev >= 0) link_valid[prev] = 1'b0;
      else if (pred >= 0) link_valid[pred] = 1'b0;
      if (cursor < k) cursor = k;
      res = '{status: cht_pkg::StDeleted, slot: found[cht_pkg::SlotW-1:0]};
      return res;
    endfunction

    function void note_request(cht_pkg::in_t req);
      if (req.operation == cht_pkg::OpInsert) pending.push_back(insert_key(req.key));
      else pending.push_back(delete_key(req.key));
    endfunction

    function void check_result(cht_pkg::out_t got);
      cht_pkg::out_t want;
      if (pending.size() == 0) begin
        faults++;
        if (faults <= ReportLimit)
          $display("unexpected result: status %0d slot %0d", got.status, got.slot);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.slot !== want.slot) begin
        faults++;
        if (faults <= ReportLimit)
          $display("mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                   want.status, want.slot, got.status, got.slot);
      end
    endfunction
  endclass

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall_o;
  cht_pkg::in_t  in_data;
  logic          out_valid_o;
  logic          out_stall;
  cht_pkg::out_t out_data_o;

  chain_table_model model = new();

  int idle_cycles = 0;
  bit calm = 1'b0;
  bit lively = 1'b1;
  bit long_hold_req = 1'b0;
  bit holding = 1'b0;
  logic [cht_pkg::KeyW-1:0] key_pool [PoolSize];

  coalesced_hash_table #(.TableSize(TableSize)) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall_o) model.note_request(in_data);
    if (rst_n && out_valid_o && !out_stall) model.check_result(out_data_o);
    if (!rst_n || (in_valid && !in_stall_o) || (out_valid_o && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int cycle;
    bit busy;
    cycle = 0;
    busy  = 1'b1;
    out_stall <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle % 100 == 0) busy = ($urandom_range(0, 2) != 0);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        holding = 1'b1;
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
        out_stall <= 1'b0;
        holding = 1'b0;
      end else if (!calm && busy && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_request(input logic op, input logic [cht_pkg::KeyW-1:0] key);
    in_data  <= '{operation: op, key: key};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall_o);
    if (!calm && lively && !long_hold_req && !holding && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (model.outstanding() != 0);
  endtask

  function automatic logic [cht_pkg::KeyW-1:0] any_key();
    logic [31:0] r;
    r = $urandom();
    return r[cht_pkg::KeyW-1:0];
  endfunction

  task automatic directed_requests();
    push_request(cht_pkg::OpDelete, 31'd5);
    push_request(cht_pkg::OpInsert, 31'd0);
    push_request(cht_pkg::OpInsert, 31'h7FFF_FFFF);
    push_request(cht_pkg::OpInsert, 31'd16);
    push_request(cht_pkg::OpInsert, 31'd32);
    push_request(cht_pkg::OpInsert, 31'd16);
    for (int i = 1; i <= 11; i++) push_request(cht_pkg::OpInsert, cht_pkg::KeyW'(i));
    push_request(cht_pkg::OpInsert, 31'h7FFF_FFF0);
    push_request(cht_pkg::OpDelete, 31'd48);
    push_request(cht_pkg::OpDelete, 31'd16);
    push_request(cht_pkg::OpDelete, 31'd16);
    push_request(cht_pkg::OpDelete, 31'd32);
    push_request(cht_pkg::OpDelete, 31'h7FFF_FFFF);
    push_request(cht_pkg::OpDelete, 31'd0);
  endtask

  task automatic random_requests(input int count);
    int pick;
    foreach (key_pool[i]) key_pool[i] = any_key();
    for (int i = 0; i < count; i++) begin
      calm = (i >= count - CalmItems);
      if (i % 50 == 0) lively = ($urandom_range(0, 2) != 0);
      if (i == LongHoldAt) long_hold_req = 1'b1;
      if (i == PauseAt) wait_for_results();
      if ($urandom_range(0, 49) == 0) key_pool[$urandom_range(0, PoolSize - 1)] = any_key();
      pick = $urandom_range(0, 99);
      if (pick < 45)
        push_request(cht_pkg::OpInsert, key_pool[$urandom_range(0, PoolSize - 1)]);
      else if (pick < 85)
        push_request(cht_pkg::OpDelete, key_pool[$urandom_range(0, PoolSize - 1)]);
      else if (pick < 93) push_request(cht_pkg::OpDelete, any_key());
      else push_request(cht_pkg::OpInsert, any_key());
    end
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_requests();
    random_requests(RandomItems);
    wait_for_results();
    repeat (DrainCycles) @(posedge clk);
    if (model.outstanding() != 0)
      $display("results missing: %0d", model.outstanding());
    if (model.faults == 0 && model.outstanding() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
